// ===== rtl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg: shared constants and types for the decimal ASCII emitter
// Widths of the binary input, the BCD image and the ASCII output digits.
// ----------------------------------------------------------------------------
package b2da_pkg;

	localparam int NUM_W      = 32;
	localparam int DIGITS     = 10;
	localparam int BCD_W      = 4 * DIGITS;
	localparam int STEP_W     = $clog2(NUM_W);
	localparam int CNT_W      = $clog2(DIGITS + 1);
	localparam int CHAR_W     = 6;
	localparam logic [1:0] ASCII_ZERO_HI = 2'b11;   // '0' is 6'b11_0000

	// status from the conversion unit to the emitter
	typedef struct packed {
		logic busy;
		logic done;
	} b2da_stat_t;

endpackage

// ===== rtl/binary_to_decimal_ascii_emitter_core.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_emitter_core: 32-bit number to ASCII decimal digits
// Converts with a serial BCD unit, strips leading zeros, emits MSD first.
// ----------------------------------------------------------------------------
// Per number: accept, a serial conversion, a load of the BCD image, then ten digit
//   positions each stripped or emitted, and a step to leave the zero strip.
// No new number is taken until the sequencer is back to idle after the last digit.
// Digits leave one per cycle unless the output side stalls.
// Reset: arst_n clears the sequencer and the output valid; no item is in flight.
module binary_to_decimal_ascii_emitter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [b2da_pkg::NUM_W-1:0]        number,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [b2da_pkg::CHAR_W-1:0]       digit_char,
	output logic                              last_digit
);
	import b2da_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_TRIM = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]        state_q;
	logic [BCD_W-1:0]  dig_q;
	logic [CNT_W-1:0]  rem_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              start;
	logic              out_free;
	logic [3:0]        top_digit;
	b2da_stat_t        stat;
	logic [BCD_W-1:0]  bcd;

	assign start     = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign top_digit = dig_q[BCD_W-1 -: 4];

	b2da_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.number (number),
		.stat   (stat),
		.bcd    (bcd)
	);

	// sequencer: convert, drop leading zeros, emit digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (stat.done) begin
						rem_q   <= CNT_W'(DIGITS);
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					if (top_digit == 4'd0 && rem_q != CNT_W'(1)) begin
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// digit shift register: load BCD image, advance one digit per shift
	always_ff @(posedge clk) begin
		if (state_q == ST_CONV && stat.done) begin
			dig_q <= bcd;
		end else if ((state_q == ST_TRIM && top_digit == 4'd0 && rem_q != CNT_W'(1))
				|| (state_q == ST_EMIT && out_free)) begin
			dig_q <= {dig_q[BCD_W-5:0], 4'd0};
		end
	end

	// output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == ST_EMIT) begin
			char_q <= {ASCII_ZERO_HI, top_digit};
			last_q <= (rem_q == CNT_W'(1));
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

endmodule

// ===== rtl/b2da_dabble.sv =====
// ----------------------------------------------------------------------------
// b2da_dabble: serial shift-and-add-3 binary to BCD converter
// Shifts the binary value in one bit per cycle, MSB first, until every input bit is in.
// ----------------------------------------------------------------------------
module b2da_dabble (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [b2da_pkg::NUM_W-1:0]    number,
	output b2da_pkg::b2da_stat_t          stat,
	output logic [b2da_pkg::BCD_W-1:0]    bcd
);
	import b2da_pkg::*;

	logic [NUM_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [STEP_W-1:0] step_q;
	logic              running_q;
	logic              done_q;
	logic [BCD_W-1:0]  adj;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// control: load, count steps, flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			step_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				step_q    <= '0;
			end else if (running_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(NUM_W - 1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	// datapath: shift binary MSB into the adjusted BCD image
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= number;
			bcd_q <= '0;
		end else if (running_q) begin
			bin_q <= {bin_q[NUM_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[NUM_W-1]};
		end
	end

	assign stat.busy = running_q;
	assign stat.done = done_q;
	assign bcd       = bcd_q;

endmodule

// ===== rtl/b2da_checker.sv =====
// ----------------------------------------------------------------------------
// b2da_checker: port-level checks for the decimal ASCII emitter
// Watches both channels and the digit codes; bound to the top level.
// ----------------------------------------------------------------------------
module b2da_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [b2da_pkg::CHAR_W-1:0]   digit_char,
	input logic                          last_digit
);
	import b2da_pkg::*;

	// an accepted number keeps the input busy for its conversion
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepting a number");

	// a stalled digit holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digit_char) && $stable(last_digit))
		else $error("output item changed while stalled");

	// every digit is an ASCII decimal digit
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_char[CHAR_W-1 -: 2] == ASCII_ZERO_HI && digit_char[3:0] <= 4'd9)
		else $error("digit outside '0' to '9'");

	// no new number is taken in the middle of a run
	a_run_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_digit |-> in_stall)
		else $error("input ready before the run ended");

endmodule

bind binary_to_decimal_ascii_emitter_core b2da_checker u_b2da_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.digit_char (digit_char),
	.last_digit (last_digit)
);
